// ===== hw/rtl/rtps_pkg.sv =====
// ----------------------------------------------------------------------------
// rtps_pkg: shared types and constants of the RTT path selector
// Field widths, command and register codes, reset values, slot control.
// ----------------------------------------------------------------------------
package rtps_pkg;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 2;
    localparam int ID_W      = 32;
    localparam int TIME_W    = 32;
    localparam int MARGIN_W  = 10;
    localparam int LOST_W    = 20;
    localparam int SUM_OUT_W = 23;
    localparam int CFG_IDX_W = 1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(20);
    localparam logic [LOST_W-1:0]   LOST_RESET   = LOST_W'(100000);

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT     = 3'd0,
        CMD_PONG       = 3'd1,
        CMD_ADD        = 3'd2,
        CMD_DELETE     = 3'd3,
        CMD_DISCONNECT = 3'd4,
        CMD_DATA       = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARGIN = 1'b0,
        CFG_LOST   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic init;
        logic ping;
        logic pong;
        logic drop;
    } t_slot_ctrl;

endpackage

// ===== hw/rtl/rtps_slot.sv =====
// ----------------------------------------------------------------------------
// rtps_slot: one endpoint slot
// RTT window as a shift line (newest at entry 0), running sum, outstanding
// ping id and send stamp.
// ----------------------------------------------------------------------------
module rtps_slot #(
    parameter int WINDOW = 5,
    parameter int SUM_W  = 23
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rtps_pkg::t_slot_ctrl         i_ctrl,
    input  logic [rtps_pkg::LOST_W-1:0]  i_lost_ms,
    input  logic [rtps_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [rtps_pkg::ID_W-1:0]    i_pong_id,
    input  logic [rtps_pkg::ID_W-1:0]    i_ping_id,
    output logic                         o_valid,
    output logic [SUM_W-1:0]             o_sum
);
    import rtps_pkg::*;

    logic [LOST_W-1:0] r_win [WINDOW];
    logic [SUM_W-1:0]  r_sum;
    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_stamp;

    logic              pong_hit;
    logic [TIME_W-1:0] elapsed;
    logic [LOST_W-1:0] el_cap;

    assign pong_hit = i_ctrl.pong && r_valid && (i_pong_id != '0) && (i_pong_id == r_id);
    assign elapsed  = i_now_ms - r_stamp;
    assign el_cap   = (elapsed > TIME_W'(i_lost_ms)) ? i_lost_ms : elapsed[LOST_W-1:0];

    // window and sum: no reset, every entry is written by an add first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= i_lost_ms;
            end
            r_sum <= SUM_W'(i_lost_ms) * SUM_W'(WINDOW);
        end else if (i_ctrl.ping) begin
            // advance the window, drop the oldest entry
            r_win[0] <= i_lost_ms;
            for (int k = 1; k < WINDOW; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_sum <= r_sum - SUM_W'(r_win[WINDOW-1]) + SUM_W'(i_lost_ms);
        end else if (pong_hit) begin
            r_win[0] <= el_cap;
            r_sum    <= r_sum - SUM_W'(r_win[0]) + SUM_W'(el_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_id    <= '0;
            r_stamp <= '0;
        end else if (i_ctrl.init) begin
            r_valid <= 1'b1;
            r_id    <= '0;
            r_stamp <= '0;
        end else if (i_ctrl.drop) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ping) begin
            r_id    <= i_ping_id;
            r_stamp <= i_now_ms;
        end else if (pong_hit) begin
            r_id    <= '0;
            r_stamp <= '0;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

// ===== hw/rtl/rtps_min_tree.sv =====
// ----------------------------------------------------------------------------
// rtps_min_tree: lowest-sum search over the valid slots
// Binary comparator tree; on equal sums the lower index wins.
// ----------------------------------------------------------------------------
module rtps_min_tree #(
    parameter int ENDPOINTS = 4,
    parameter int SUM_W     = 23,
    parameter int IW        = 2
) (
    input  logic [ENDPOINTS-1:0] i_valid,
    input  logic [SUM_W-1:0]     i_sum [ENDPOINTS],
    output logic                 o_any,
    output logic                 o_multi,
    output logic [IW-1:0]        o_best,
    output logic [SUM_W-1:0]     o_best_sum
);
    localparam int NP    = 1 << $clog2(ENDPOINTS);
    localparam int NODES = 2 * NP - 1;

    logic             node_v [NODES];
    logic [IW-1:0]    node_i [NODES];
    logic [SUM_W-1:0] node_s [NODES];

    always_comb begin
        for (int k = 0; k < NP; k++) begin
            if (k < ENDPOINTS) begin
                node_v[NP-1+k] = i_valid[k];
                node_i[NP-1+k] = IW'(k);
                node_s[NP-1+k] = i_sum[k];
            end else begin
                node_v[NP-1+k] = 1'b0;
                node_i[NP-1+k] = '0;
                node_s[NP-1+k] = '0;
            end
        end
        for (int n = NP - 2; n >= 0; n--) begin
            // left child holds the lower indices: keep it on a tie
            if (node_v[2*n+1] && (!node_v[2*n+2] || node_s[2*n+1] <= node_s[2*n+2])) begin
                node_v[n] = 1'b1;
                node_i[n] = node_i[2*n+1];
                node_s[n] = node_s[2*n+1];
            end else begin
                node_v[n] = node_v[2*n+2];
                node_i[n] = node_i[2*n+2];
                node_s[n] = node_s[2*n+2];
            end
        end
    end

    assign o_any      = |i_valid;
    assign o_multi    = |(i_valid & (i_valid - ENDPOINTS'(1)));
    assign o_best     = node_i[0];
    assign o_best_sum = node_s[0];

endmodule

// ===== hw/rtl/rtt_path_selector.sv =====
// ----------------------------------------------------------------------------
// rtt_path_selector: RTT-based active path selection with hysteresis
//
// Request channel (i_in_valid / o_in_stall) carries a command, a slot index,
// a pong id and the current time in ms. A request is taken at a rising edge
// with i_in_valid high and o_in_stall low. Every request yields exactly one
// result on the result channel (o_out_valid / i_out_stall): the active path,
// its window sum, and the ping id if this request pinged the slots.
// Pipeline: request register, then one pass of logic into the state and the
// result register. Throughput: one request per cycle while the result is
// not stalled; the pass is the lowest-sum comparator tree over the slots
// followed by the hysteresis compare.
// Stall: a stalled result holds, together with the slot state that it shows;
// one more request waits in the request register, then o_in_stall rises.
// Reset (i_rst_n low, synchronous): all slots invalid, no active path,
// sequence counter zero, margin 20 ms, lost-ping value 100000 ms.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 margin,
// index 1 lost-ping value; write only while no request is in flight.
// ----------------------------------------------------------------------------
module rtt_path_selector #(
    parameter int ENDPOINTS = 4,
    parameter int WINDOW    = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rtps_pkg::CMD_W-1:0]       i_command,
    input  logic [rtps_pkg::IDX_W-1:0]       i_endpoint_index,
    input  logic [rtps_pkg::ID_W-1:0]        i_pong_id,
    input  logic [rtps_pkg::TIME_W-1:0]      i_now_ms,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_active_valid,
    output logic [rtps_pkg::IDX_W-1:0]       o_active_index,
    output logic                             o_ping_issued,
    output logic [rtps_pkg::ID_W-1:0]        o_ping_id,
    output logic [rtps_pkg::SUM_OUT_W-1:0]   o_active_sum,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rtps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtps_pkg::LOST_W-1:0]      i_cfg_data
);
    import rtps_pkg::*;

    localparam int IW    = $clog2(ENDPOINTS);
    localparam int SUM_W = LOST_W + $clog2(WINDOW);
    localparam int THR_W = MARGIN_W + $clog2(WINDOW + 1);

    // configuration registers
    logic [MARGIN_W-1:0] r_margin;
    logic [LOST_W-1:0]   r_lost;

    // request register
    logic              r_p_valid;
    logic [CMD_W-1:0]  r_p_cmd;
    logic [IDX_W-1:0]  r_p_idx;
    logic [ID_W-1:0]   r_p_pid;
    logic [TIME_W-1:0] r_p_now;

    // result register and block state
    logic              r_o_valid;
    logic              r_o_ping;
    logic [ID_W-1:0]   r_o_id;
    logic              r_act_flag;
    logic [IW-1:0]     r_act_slot;
    logic [ID_W-1:0]   r_seq;

    logic              n_act_flag;
    logic [IW-1:0]     n_act_slot;
    logic [ID_W-1:0]   n_seq;

    logic              out_free;
    logic              fire;
    logic              in_take;

    logic [ENDPOINTS-1:0] slot_valid;
    logic [SUM_W-1:0]     slot_sum  [ENDPOINTS];
    t_slot_ctrl           slot_ctrl [ENDPOINTS];

    logic              any_valid;
    logic              multi_valid;
    logic [IW-1:0]     best;
    logic [SUM_W-1:0]  best_sum;

    logic              idx_ok;
    logic [IW-1:0]     sel;
    logic              sel_valid;
    logic              act_on_sel;
    logic              act_ok;
    logic [SUM_W-1:0]  diff;
    logic [THR_W-1:0]  thr;
    logic              do_ping;
    logic              do_add;
    logic              do_pong;
    logic              do_drop;

    // ---- handshake: request register and result register ----
    assign out_free    = !r_o_valid || !i_out_stall;
    assign fire        = r_p_valid && out_free;
    assign o_in_stall  = r_p_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (in_take) begin
            r_p_valid <= 1'b1;
        end else if (fire) begin
            r_p_valid <= 1'b0;
        end
    end

    // hold the request payload until it is taken in
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_p_cmd <= i_command;
            r_p_idx <= i_endpoint_index;
            r_p_pid <= i_pong_id;
            r_p_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
            r_lost   <= LOST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MARGIN: r_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_LOST:   r_lost   <= i_cfg_data;
                default:    r_margin <= r_margin;
            endcase
        end
    end

    // ---- slots and lowest-sum search ----
    for (genvar g = 0; g < ENDPOINTS; g++) begin : g_slot
        rtps_slot #(
            .WINDOW (WINDOW),
            .SUM_W  (SUM_W)
        ) u_slot (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (slot_ctrl[g]),
            .i_lost_ms (r_lost),
            .i_now_ms  (r_p_now),
            .i_pong_id (r_p_pid),
            .i_ping_id (n_seq),
            .o_valid   (slot_valid[g]),
            .o_sum     (slot_sum[g])
        );
    end

    rtps_min_tree #(
        .ENDPOINTS (ENDPOINTS),
        .SUM_W     (SUM_W),
        .IW        (IW)
    ) u_min (
        .i_valid    (slot_valid),
        .i_sum      (slot_sum),
        .o_any      (any_valid),
        .o_multi    (multi_valid),
        .o_best     (best),
        .o_best_sum (best_sum)
    );

    // ---- decode ----
    assign idx_ok     = 32'(r_p_idx) < 32'(ENDPOINTS);
    assign sel        = IW'(r_p_idx);
    assign sel_valid  = idx_ok && slot_valid[sel];
    assign act_on_sel = idx_ok && r_act_flag && (r_act_slot == sel);
    assign act_ok     = r_act_flag && slot_valid[r_act_slot];
    // best is the minimum, so the difference never goes below zero
    assign diff       = slot_sum[r_act_slot] - best_sum;
    assign thr        = THR_W'(r_margin) * THR_W'(WINDOW);

    always_comb begin
        n_act_flag = r_act_flag;
        n_act_slot = r_act_slot;
        n_seq      = r_seq;
        do_ping    = 1'b0;
        do_add     = 1'b0;
        do_pong    = 1'b0;
        do_drop    = 1'b0;
        case (r_p_cmd)
            CMD_SELECT: begin
                if (any_valid && !multi_valid) begin
                    // a single valid slot: take it, no ping
                    n_act_flag = 1'b1;
                    n_act_slot = best;
                end else if (multi_valid) begin
                    if (!act_ok) begin
                        n_act_flag = 1'b1;
                        n_act_slot = best;
                    end else if (r_act_slot != best &&
                                 32'(diff) > 32'(thr)) begin
                        n_act_slot = best;
                    end
                    n_seq   = r_seq + ID_W'(1);
                    do_ping = 1'b1;
                end
            end
            CMD_PONG: begin
                do_pong = idx_ok;
            end
            CMD_ADD: begin
                do_add = idx_ok;
            end
            CMD_DELETE: begin
                if (sel_valid) begin
                    do_drop = 1'b1;
                    if (act_on_sel) begin
                        n_act_flag = 1'b0;
                        n_act_slot = '0;
                    end
                end
            end
            CMD_DISCONNECT: begin
                if (act_on_sel) begin
                    n_act_flag = 1'b0;
                    n_act_slot = '0;
                end
            end
            CMD_DATA: begin
                if (!r_act_flag && sel_valid) begin
                    n_act_flag = 1'b1;
                    n_act_slot = sel;
                end
            end
            default: begin
                n_act_flag = r_act_flag;
            end
        endcase
    end

    // gate every slot update with fire so a stalled result keeps its state
    always_comb begin
        for (int k = 0; k < ENDPOINTS; k++) begin
            slot_ctrl[k].init = fire && do_add  && (sel == IW'(k));
            slot_ctrl[k].pong = fire && do_pong && (sel == IW'(k));
            slot_ctrl[k].drop = fire && do_drop && (sel == IW'(k));
            slot_ctrl[k].ping = fire && do_ping && slot_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_flag <= 1'b0;
            r_act_slot <= '0;
            r_seq      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_act_flag <= n_act_flag;
                r_act_slot <= n_act_slot;
                r_seq      <= n_seq;
                r_o_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_ping <= do_ping;
            r_o_id   <= do_ping ? n_seq : '0;
        end
    end

    // ---- result fields ----
    // Slot state moves only when a new result is loaded, so the active fields
    // read straight from it always match the result on display.
    assign o_out_valid    = r_o_valid;
    assign o_active_valid = r_act_flag;
    assign o_active_index = r_act_flag ? IDX_W'(r_act_slot) : '0;
    assign o_active_sum   = r_act_flag ? SUM_OUT_W'(slot_sum[r_act_slot]) : '0;
    assign o_ping_issued  = r_o_ping;
    assign o_ping_id      = r_o_id;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RTT path selector
// Runs a directed request list and then random phases under several margin
// and lost-ping settings. A clocked driver feeds requests from a backlog
// queue and a clocked monitor compares every result against a model of the
// slot windows, sums and active path. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import rtps_pkg::*;

    localparam int ENDPOINTS   = 4;
    localparam int WINDOW      = 5;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;

    // Codes the block must ignore.
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    // One request. echo_id takes the pong id from the slot's outstanding
    // ping, rel_now turns now into an offset from the slot's ping stamp;
    // both are resolved when the request goes onto the bus.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] now;
        logic              echo_id;
        logic              rel_now;
    } t_request;

    typedef struct packed {
        logic                 act;
        logic [IDX_W-1:0]     idx;
        logic                 ping;
        logic [ID_W-1:0]      id;
        logic [SUM_OUT_W-1:0] sum;
    } t_path_status;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_command        = '0;
    logic [IDX_W-1:0]     i_endpoint_index = '0;
    logic [ID_W-1:0]      i_pong_id        = '0;
    logic [TIME_W-1:0]    i_now_ms         = '0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic                 o_active_valid;
    logic [IDX_W-1:0]     o_active_index;
    logic                 o_ping_issued;
    logic [ID_W-1:0]      o_ping_id;
    logic [SUM_OUT_W-1:0] o_active_sum;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [LOST_W-1:0]    i_cfg_data       = '0;

    rtt_path_selector #(
        .ENDPOINTS(ENDPOINTS),
        .WINDOW   (WINDOW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_endpoint_index(i_endpoint_index),
        .i_pong_id       (i_pong_id),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_active_valid  (o_active_valid),
        .o_active_index  (o_active_index),
        .o_ping_issued   (o_ping_issued),
        .o_ping_id       (o_ping_id),
        .o_active_sum    (o_active_sum),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Path model state: a private copy of the slots and the settings
    // ------------------------------------------------------------------------
    logic [MARGIN_W-1:0] margin_cfg;
    logic [LOST_W-1:0]   lost_cfg;

    bit          slot_live    [ENDPOINTS];
    bit [31:0]   rtt_hist     [ENDPOINTS][WINDOW];
    int unsigned hist_head    [ENDPOINTS];
    bit [31:0]   hist_sum     [ENDPOINTS];
    bit [31:0]   ping_seq_of  [ENDPOINTS];
    bit [31:0]   ping_sent_at [ENDPOINTS];
    bit          path_on;
    int unsigned path_slot;
    bit [31:0]   seq_ctr;

    t_request     req_backlog[$];   // requests not yet taken by the block
    t_path_status status_due[$];    // predicted results, oldest first
    t_request     cur_req;          // request currently on the bus
    int unsigned  req_gap;
    int unsigned  rx_hold;
    int unsigned  idle_pct;
    int unsigned  quiet_cycles;
    int           mismatches;

    // Append one RTT sample, dropping the oldest from the running sum.
    function automatic void push_rtt(int unsigned s, bit [31:0] v);
        int unsigned n;
        n = (hist_head[s] + 1) % WINDOW;
        hist_sum[s]    = hist_sum[s] - rtt_hist[s][n] + v;
        rtt_hist[s][n] = v;
        hist_head[s]   = n;
    endfunction

    // Apply one taken request to the model and queue the result it causes.
    function automatic void advance_paths(t_request r);
        int unsigned  live;
        int unsigned  best;
        int unsigned  n;
        bit [31:0]    best_sum;
        bit [31:0]    elapsed;
        bit [31:0]    lost32;
        bit [31:0]    span;
        t_path_status st;
        st       = '0;
        live     = 0;
        best     = 0;
        best_sum = 0;
        lost32   = 32'(lost_cfg);
        span     = 32'(margin_cfg) * 32'(WINDOW);
        case (r.cmd)
            CMD_SELECT: begin
                for (int s = 0; s < ENDPOINTS; s++) begin
                    if (slot_live[s]) begin
                        // strict compare keeps the lowest index on a tie
                        if (live == 0 || hist_sum[s] < best_sum) begin
                            best     = s;
                            best_sum = hist_sum[s];
                        end
                        live++;
                    end
                end
                if (live == 1) begin
                    // a lone slot is taken without a ping
                    path_on   = 1'b1;
                    path_slot = best;
                end else if (live > 1) begin
                    if (!(path_on && slot_live[path_slot])) begin
                        path_on   = 1'b1;
                        path_slot = best;
                    end else if (path_slot != best &&
                                 hist_sum[path_slot] - best_sum > span) begin
                        path_slot = best;
                    end
                    seq_ctr = seq_ctr + 1;
                    st.ping = 1'b1;
                    st.id   = seq_ctr;
                    for (int s = 0; s < ENDPOINTS; s++) begin
                        if (slot_live[s]) begin
                            ping_seq_of[s]  = seq_ctr;
                            ping_sent_at[s] = r.now;
                            push_rtt(s, lost32);
                        end
                    end
                end
            end
            CMD_PONG: begin
                if (slot_live[r.idx] && r.pid != 0 && r.pid == ping_seq_of[r.idx]) begin
                    elapsed = r.now - ping_sent_at[r.idx];
                    if (elapsed > lost32) begin
                        elapsed = lost32;
                    end
                    n = hist_head[r.idx] % WINDOW;
                    hist_sum[r.idx]     = hist_sum[r.idx] - rtt_hist[r.idx][n] + elapsed;
                    rtt_hist[r.idx][n]  = elapsed;
                    ping_seq_of[r.idx]  = 0;
                    ping_sent_at[r.idx] = 0;
                end
            end
            CMD_ADD: begin
                // a live slot is simply reinitialized
                for (int k = 0; k < WINDOW; k++) begin
                    rtt_hist[r.idx][k] = lost32;
                end
                hist_sum[r.idx]     = lost32 * 32'(WINDOW);
                hist_head[r.idx]    = WINDOW - 1;
                ping_seq_of[r.idx]  = 0;
                ping_sent_at[r.idx] = 0;
                slot_live[r.idx]    = 1'b1;
            end
            CMD_DELETE: begin
                if (slot_live[r.idx]) begin
                    slot_live[r.idx] = 1'b0;
                    if (path_on && path_slot == 32'(r.idx)) begin
                        path_on   = 1'b0;
                        path_slot = 0;
                    end
                end
            end
            CMD_DISCONNECT: begin
                if (path_on && path_slot == 32'(r.idx)) begin
                    path_on   = 1'b0;
                    path_slot = 0;
                end
            end
            CMD_DATA: begin
                if (!path_on && slot_live[r.idx]) begin
                    path_on   = 1'b1;
                    path_slot = 32'(r.idx);
                end
            end
            default: begin
            end
        endcase
        if (path_on) begin
            st.act = 1'b1;
            st.idx = IDX_W'(path_slot);
            st.sum = hist_sum[path_slot][SUM_OUT_W-1:0];
        end
        status_due.push_back(st);
    endfunction

    // Mostly short gaps, now and then a long one; none when idle_pct is 0.
    function automatic int unsigned pick_gap();
        if (idle_pct == 0 || $urandom_range(99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(7) == 0) begin
            return $urandom_range(24, 6);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic t_request mk_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                        logic [ID_W-1:0] pid, logic [TIME_W-1:0] now,
                                        logic echo_id, logic rel_now);
        t_request r;
        r.cmd     = cmd;
        r.idx     = idx;
        r.pid     = pid;
        r.now     = now;
        r.echo_id = echo_id;
        r.rel_now = rel_now;
        return r;
    endfunction

    // Weighted toward selects and answered pongs so the windows keep moving.
    function automatic t_request rand_request();
        t_request    r;
        int unsigned pick;
        r      = '0;
        r.idx  = IDX_W'($urandom_range(3));
        r.pid  = $urandom();
        r.now  = $urandom();
        pick   = $urandom_range(99);
        if (pick < 25) begin
            r.cmd = CMD_SELECT;
        end else if (pick < 60) begin
            r.cmd     = CMD_PONG;
            r.echo_id = ($urandom_range(9) != 0);
            r.rel_now = ($urandom_range(9) != 0);
            if (r.rel_now) begin
                case ($urandom_range(9))
                    0, 1:    r.now = $urandom_range(50);
                    9:       r.now = $urandom();
                    default: r.now = $urandom_range(32'(lost_cfg) + 32'(lost_cfg) / 4);
                endcase
            end
        end else if (pick < 70) begin
            r.cmd = CMD_ADD;
        end else if (pick < 77) begin
            r.cmd = CMD_DELETE;
        end else if (pick < 84) begin
            r.cmd = CMD_DISCONNECT;
        end else if (pick < 95) begin
            r.cmd = CMD_DATA;
        end else begin
            r.cmd = $urandom_range(1) ? CMD_RSVD_LO : CMD_RSVD_HI;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // Write one register and mirror it into the model's settings.
    task automatic write_reg(input t_cfg_reg reg_idx, input logic [LOST_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (reg_idx == CFG_MARGIN) begin
            margin_cfg = value[MARGIN_W-1:0];
        end else begin
            lost_cfg = value;
        end
    endtask

    // Wait until every queued request is taken and every result is back.
    task automatic drain();
        while (req_backlog.size() != 0 || status_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: hold a request until taken, then predict and advance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        bit       drive_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            drive_valid = i_in_valid;
            // taken at this edge: predict, drop from backlog, draw the next gap
            if (i_in_valid && !o_in_stall) begin
                advance_paths(cur_req);
                void'(req_backlog.pop_front());
                req_gap     = pick_gap();
                drive_valid = 1'b0;
            end
            if (!drive_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (req_backlog.size() != 0) begin
                    // resolve echoed ids and relative times against the model now
                    nxt = req_backlog[0];
                    if (nxt.echo_id) begin
                        nxt.pid = ping_seq_of[nxt.idx];
                    end
                    if (nxt.rel_now) begin
                        nxt.now = ping_sent_at[nxt.idx] + nxt.now;
                    end
                    cur_req          = nxt;
                    i_command        <= nxt.cmd;
                    i_endpoint_index <= nxt.idx;
                    i_pong_id        <= nxt.pid;
                    i_now_ms         <= nxt.now;
                    drive_valid      = 1'b1;
                end
            end
            i_in_valid <= drive_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare taken results, stall at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_path_status want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    report_mismatch("result with no request", 32'(o_active_index), 0);
                end else begin
                    want = status_due.pop_front();
                    if (o_active_valid !== want.act)
                        report_mismatch("active_valid", 32'(o_active_valid), 32'(want.act));
                    if (o_active_index !== want.idx)
                        report_mismatch("active_index", 32'(o_active_index), 32'(want.idx));
                    if (o_ping_issued !== want.ping)
                        report_mismatch("ping_issued", 32'(o_ping_issued), 32'(want.ping));
                    if (o_ping_id !== want.id)
                        report_mismatch("ping_id", o_ping_id, want.id);
                    if (o_active_sum !== want.sum)
                        report_mismatch("active_sum", 32'(o_active_sum), 32'(want.sum));
                end
            end
            // hold a stall run until it runs out, then maybe start another
            if (rx_hold == 0) begin
                rx_hold = pick_gap();
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_progress
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed list, then random phases under varied settings
    // ------------------------------------------------------------------------
    initial begin : run_stimulus
        logic [MARGIN_W-1:0] margin_set;
        logic [LOST_W-1:0]   lost_set;
        margin_cfg   = MARGIN_RESET;
        lost_cfg     = LOST_RESET;
        path_on      = 1'b0;
        path_slot    = 0;
        seq_ctr      = 0;
        req_gap      = 0;
        rx_hold      = 0;
        quiet_cycles = 0;
        mismatches   = 0;
        idle_pct     = 30;
        for (int s = 0; s < ENDPOINTS; s++) begin
            slot_live[s]    = 1'b0;
            hist_head[s]    = 0;
            hist_sum[s]     = 0;
            ping_seq_of[s]  = 0;
            ping_sent_at[s] = 0;
            for (int k = 0; k < WINDOW; k++) begin
                rtt_hist[s][k] = 0;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every event must be ignored
        req_backlog.push_back(mk_req(CMD_SELECT, 2'd3, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_PONG, 2'd0, '1, '1, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DELETE, 2'd2, '0, '1, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DATA, 2'd1, '1, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DISCONNECT, 2'd0, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_RSVD_LO, 2'd1, '1, '1, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_RSVD_HI, 2'd2, '0, '0, 1'b0, 1'b0));
        // lone slot is taken without a ping
        req_backlog.push_back(mk_req(CMD_ADD, 2'd0, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_SELECT, 2'd0, '0, 32'd7, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_ADD, 2'd1, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_ADD, 2'd2, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_ADD, 2'd3, '0, '0, 1'b0, 1'b0));
        // ping just below the time wrap, all sums tied
        req_backlog.push_back(mk_req(CMD_SELECT, 2'd1, '0, 32'hFFFF_FFF0, 1'b0, 1'b0));
        // answered across the wrap, then a zero id on a cleared slot
        req_backlog.push_back(mk_req(CMD_PONG, 2'd1, '0, 32'd20, 1'b1, 1'b1));
        req_backlog.push_back(mk_req(CMD_PONG, 2'd1, '0, 32'd3, 1'b0, 1'b1));
        // wrong id, then an elapsed time past the cap, then zero elapsed
        req_backlog.push_back(mk_req(CMD_PONG, 2'd2, 32'd12345, 32'd9, 1'b0, 1'b1));
        req_backlog.push_back(mk_req(CMD_PONG, 2'd2, '0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        req_backlog.push_back(mk_req(CMD_PONG, 2'd3, '0, 32'd0, 1'b1, 1'b1));
        // switch to the best slot
        req_backlog.push_back(mk_req(CMD_SELECT, 2'd0, '0, '0, 1'b0, 1'b0));
        // data with a path set, disconnect of another slot, then of the active
        req_backlog.push_back(mk_req(CMD_DATA, 2'd2, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DISCONNECT, 2'd0, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DISCONNECT, 2'd3, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DATA, 2'd2, '0, '0, 1'b0, 1'b0));
        // re-add the live active slot, then delete it
        req_backlog.push_back(mk_req(CMD_ADD, 2'd2, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_DELETE, 2'd2, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(CMD_SELECT, 2'd3, '0, '1, 1'b0, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin margin_set = 10'd0;    lost_set = 20'd1000000; idle_pct = 30; end
                1: begin margin_set = 10'd1000; lost_set = 20'd1;       idle_pct = 50; end
                2: begin
                    margin_set = MARGIN_W'($urandom_range(1000));
                    lost_set   = LOST_W'($urandom_range(1000000, 1));
                    idle_pct   = 0;
                end
                3: begin margin_set = 10'd20;   lost_set = 20'd100000;  idle_pct = 20; end
                4: begin margin_set = 10'd1000; lost_set = 20'd1000000; idle_pct = 70; end
                default: begin margin_set = 10'd0; lost_set = 20'd1; idle_pct = 10; end
            endcase
            write_reg(CFG_MARGIN, LOST_W'(margin_set));
            write_reg(CFG_LOST, lost_set);
            repeat (PHASE_ITEMS) req_backlog.push_back(rand_request());
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rtps_pkg.sv
hw/rtl/rtps_slot.sv
hw/rtl/rtps_min_tree.sv
hw/rtl/rtt_path_selector.sv
tb/sv/testbench.sv
